[rtl/cis_pkg.sv]
package cis_pkg;

    // request fields
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } t_in;

    // result fields
    typedef struct packed {
        logic [1:0]  status;
        logic        head_done;
        logic [2:0]  head_major;
        logic [63:0] head_argument;
        logic [63:0] items_pending;
    } t_out;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEAD    = 3'b001,
        PH_ARG     = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // parser state carried from byte to byte
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  arg_left;
        logic [63:0] arg_acc;
        logic [2:0]  major;
        logic [63:0] pending;
        logic [63:0] payload_left;
    } t_state;

    // status codes
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_UNSUP = 2'd3;

    // major types
    localparam logic [2:0] MT_BSTR   = 3'd2;
    localparam logic [2:0] MT_TSTR   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    // additional info codes
    localparam logic [4:0] INFO_ARG1 = 5'd24;
    localparam logic [4:0] INFO_RSVD = 5'd28;

    localparam logic [63:0] ALL_ONES = '1;

    localparam t_state STATE_RESET = '{
        phase:        PH_HEAD,
        arg_left:     4'd0,
        arg_acc:      64'd0,
        major:        3'd0,
        pending:      64'd1,
        payload_left: 64'd0
    };

endpackage

[rtl/cis_step.sv]
module cis_step (
    input  cis_pkg::t_state i_state,
    input  cis_pkg::t_in    i_req,
    output cis_pkg::t_state o_state,
    output cis_pkg::t_out   o_res
);
    import cis_pkg::*;

    t_state      s;
    logic [2:0]  hdr_major;
    logic [4:0]  hdr_info;
    logic        unsup;
    logic        hd;
    logic [63:0] hv;
    logic [63:0] p_dec;
    logic [63:0] addend;
    logic [64:0] p_sum;

    assign hdr_major = i_req.data_byte[7:5];
    assign hdr_info  = i_req.data_byte[4:0];

    always_comb begin
        s      = i_state;
        unsup  = 1'b0;
        hd     = 1'b0;
        hv     = 64'd0;
        p_dec  = 64'd0;
        addend = 64'd0;
        p_sum  = 65'd0;

        // per-phase byte handling
        case (i_state.phase)
            PH_HEAD: begin
                if (hdr_major == MT_SIMPLE || hdr_info >= INFO_RSVD) begin
                    unsup = 1'b1;
                end else begin
                    s.major = hdr_major;
                    if (hdr_info < INFO_ARG1) begin
                        hd = 1'b1;
                        hv = {59'd0, hdr_info};
                    end else begin
                        // info 24..27 selects 1, 2, 4 or 8 argument bytes
                        s.arg_left = 4'd1 << hdr_info[1:0];
                        s.arg_acc  = 64'd0;
                        s.phase    = PH_ARG;
                    end
                end
            end
            PH_ARG: begin
                s.arg_acc = {i_state.arg_acc[55:0], i_req.data_byte};
                if (i_state.arg_left != 4'd0) begin
                    s.arg_left = i_state.arg_left - 4'd1;
                end
                if (s.arg_left == 4'd0) begin
                    hd = 1'b1;
                    hv = s.arg_acc;
                end
            end
            PH_PAYLOAD: begin
                if (i_state.payload_left != 64'd0) begin
                    s.payload_left = i_state.payload_left - 64'd1;
                end
                if (s.payload_left == 64'd0) begin
                    s.phase = PH_HEAD;
                end
            end
            default: begin
                s = STATE_RESET;
            end
        endcase

        // a finished head consumes one pending item and may add more
        if (hd) begin
            p_dec   = (s.pending != 64'd0) ? s.pending - 64'd1 : s.pending;
            s.phase = PH_HEAD;
            case (s.major)
                MT_BSTR, MT_TSTR: begin
                    if (hv != 64'd0) begin
                        s.payload_left = hv;
                        s.phase        = PH_PAYLOAD;
                    end
                end
                MT_ARRAY: addend = hv;
                MT_MAP:   addend = hv[63] ? ALL_ONES : {hv[62:0], 1'b0};
                MT_TAG:   addend = 64'd1;
                default:  addend = 64'd0;
            endcase
            p_sum     = {1'b0, p_dec} + {1'b0, addend};
            s.pending = p_sum[64] ? ALL_ONES : p_sum[63:0];
        end
    end

    // result and end-of-item handling
    always_comb begin
        o_state             = s;
        o_res.head_done     = hd;
        o_res.head_major    = hd ? s.major : 3'd0;
        o_res.head_argument = hd ? hv : 64'd0;
        o_res.items_pending = s.pending;
        o_res.status        = ST_BUSY;
        if (unsup) begin
            o_res.status        = ST_UNSUP;
            o_res.head_done     = 1'b0;
            o_res.head_major    = 3'd0;
            o_res.head_argument = 64'd0;
            o_res.items_pending = i_state.pending;
            o_state             = STATE_RESET;
        end else if (s.phase == PH_HEAD && s.pending == 64'd0) begin
            o_res.status        = ST_DONE;
            o_res.items_pending = 64'd0;
            o_state             = STATE_RESET;
        end else if (i_req.buffer_last) begin
            o_res.status = ST_TRUNC;
            o_state      = STATE_RESET;
        end
    end

endmodule

[rtl/cbor_item_skipper.sv]
// channel | handshake          | payload
// --------+--------------------+-------------------------------------------
// request | i_valid / o_ready  | i_data: data_byte, buffer_last
// result  | o_valid / i_ready  | o_data: status, head_done, head_major,
//         |                    |         head_argument, items_pending
//
// one byte per cycle sustained while the result is not stalled; each byte yields exactly one result.
// a byte passes the input register, then parse logic into the result register.
// the parse state updates in the same cycle the byte moves into the result register.
// synchronous active-low reset empties both registers and restores the parse state.
// a stalled result holds the byte in the input register; o_ready stays high while
// the result register drains in the same cycle.
module cbor_item_skipper (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cis_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cis_pkg::t_out   o_data
);
    import cis_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;
    logic   out_free;
    logic   advance;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // byte parser
    cis_step u_step (
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/cis_checker.sv]
module cis_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input cis_pkg::t_in    i_data,
    input logic            o_valid,
    input logic            i_ready,
    input cis_pkg::t_out   o_data
);
    import cis_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // waiting request holds
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("waiting request changed");

    // completed item leaves nothing pending
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_DONE |-> o_data.items_pending == 64'd0)
        else $error("item complete with items pending");

    // head fields are zero without a finished head
    a_head_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.head_done |->
            o_data.head_major == 3'd0 && o_data.head_argument == 64'd0)
        else $error("head fields set without head_done");

endmodule

bind cbor_item_skipper cis_checker u_cis_checker (.*);
